// ----- design/pcd_pkg.sv -----
package pcd_pkg;

	localparam int BYTE_BITS = 8;
	localparam int LEN_W     = 4;
	localparam int CNT_W     = 5;
	localparam int BUF_W     = 16;
	localparam int TOTAL_W   = 9;
	localparam int NSYM_W    = 4;
	localparam int MAX_RES   = 8;

	typedef enum logic [1:0] {
		DEC_NONE  = 2'b00,
		DEC_MATCH = 2'b01,
		DEC_WAIT  = 2'b10
	} dec_kind_t;

	typedef struct packed {
		logic [BYTE_BITS-1:0] sym;
		logic [LEN_W-1:0]     len;
		logic [BYTE_BITS-1:0] code;
	} entry_t;

	typedef struct packed {
		logic                 valid;
		dec_kind_t            kind;
		logic [BYTE_BITS-1:0] sym;
		logic [LEN_W-1:0]     len;
	} token_t;

	typedef struct packed {
		logic [BUF_W-1:0] bits;
		logic [CNT_W-1:0] avail;
		logic             at_end;
	} query_t;

	// Mask of the k low bits of a byte, k from 0 to 8.
	function automatic logic [BYTE_BITS-1:0] low_mask8(input logic [LEN_W-1:0] k);
		logic [BYTE_BITS:0] m;
		m = (9'd1 << k) - 9'd1;
		return m[BYTE_BITS-1:0];
	endfunction

endpackage

// ----- design/pcd_in_if.sv -----
interface pcd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] file_byte;
	logic       file_end;

	modport source (output valid, output file_byte, output file_end, input ready);
	modport sink (input valid, input file_byte, input file_end, output ready);
endinterface

// ----- design/pcd_out_if.sv -----
interface pcd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] symbol;
	logic       symbol_valid;
	logic       run_end;
	logic       message_done;
	logic       decode_error;

	modport source (output valid, output symbol, output symbol_valid, output run_end,
		output message_done, output decode_error, input ready);
	modport sink (input valid, input symbol, input symbol_valid, input run_end,
		input message_done, input decode_error, output ready);
endinterface

// ----- design/pcd_cell.sv -----
module pcd_cell import pcd_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   clear,
	input  logic   push,
	input  entry_t entry_in,
	input  logic   valid_in,
	input  query_t query,
	input  token_t tok_in,
	output entry_t entry_out,
	output logic   valid_out,
	output token_t tok_out
);

	entry_t entry_q;
	logic   ent_valid_q;
	token_t tok_q;

	logic [CNT_W-1:0]     sh;
	logic [BUF_W-1:0]     shifted;
	logic [BYTE_BITS-1:0] lhs;
	logic [BYTE_BITS-1:0] rhs;
	logic                 live;
	logic                 hit_match;
	logic                 hit_wait;
	token_t               tok_next;

	// A cell either decodes the buffer head with its code, or tells the search to wait
	// because its longer code still agrees with every bit buffered so far.
	always_comb begin
		live      = ent_valid_q && (entry_q.len != '0);
		sh        = query.avail - {1'b0, entry_q.len};
		shifted   = query.bits >> sh;
		lhs       = shifted[BYTE_BITS-1:0] & low_mask8(entry_q.len);
		rhs       = entry_q.code >> (LEN_W'(BYTE_BITS) - entry_q.len);
		hit_match = live && ({1'b0, entry_q.len} <= query.avail) && (lhs == rhs);
		hit_wait  = live && ({1'b0, entry_q.len} > query.avail) && !query.at_end
			&& (query.bits == {8'd0, entry_q.code >> (LEN_W'(BYTE_BITS) - query.avail[LEN_W-1:0])});
		tok_next = tok_in;
		if (tok_in.valid && tok_in.kind == DEC_NONE) begin
			if (hit_match) begin
				tok_next.kind = DEC_MATCH;
				tok_next.sym  = entry_q.sym;
				tok_next.len  = entry_q.len;
			end else if (hit_wait) begin
				tok_next.kind = DEC_WAIT;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_valid_q <= 1'b0;
			tok_q       <= '0;
		end else begin
			tok_q <= tok_next;
			if (clear) begin
				ent_valid_q <= 1'b0;
			end else if (push) begin
				ent_valid_q <= valid_in;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q <= entry_in;
		end
	end

	assign entry_out = entry_q;
	assign valid_out = ent_valid_q;
	assign tok_out   = tok_q;

endmodule

// ----- design/prefix_code_stream_decoder.sv -----
// Header bytes give no result unless the file ends early.
// A table search runs a token through all MAX_ENTRIES cells, one cell after another, and is
// skipped when the bit buffer is empty. A data byte runs one search per matched code plus a
// closing one (none after a ninth match), and a busy output can stall the sequencer.
// Asynchronous reset (arst_n low) returns the parser to the count byte and empties every cell.
module prefix_code_stream_decoder import pcd_pkg::*; #(
	parameter int MAX_ENTRIES = 256,
	parameter int CODE_BITS   = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	pcd_in_if.sink    in_ch,
	pcd_out_if.source out_ch
);

	// Parse phase of the current file, one-hot.
	typedef enum logic [4:0] {
		PH_COUNT  = 5'b00001,
		PH_TRIPLE = 5'b00010,
		PH_FINAL  = 5'b00100,
		PH_DATA   = 5'b01000,
		PH_DRAIN  = 5'b10000
	} phase_t;

	// Control sequencer, one-hot.
	//   C_IDLE    waits for an input transfer.
	//   C_LAUNCH  starts a table search for the buffer head.
	//   C_SEARCH  waits for the token to leave the last cell.
	//   C_DECIDE  acts on the search outcome and emits results.
	//   C_HDR_END emits the error result of a file cut short in its header.
	typedef enum logic [4:0] {
		C_IDLE    = 5'b00001,
		C_LAUNCH  = 5'b00010,
		C_SEARCH  = 5'b00100,
		C_DECIDE  = 5'b01000,
		C_HDR_END = 5'b10000
	} ctl_t;

	phase_t               phase_q;
	ctl_t                 ctl_q;
	logic [TOTAL_W-1:0]   entries_total_q;
	logic [TOTAL_W-1:0]   load_index_q;
	logic [1:0]           tpos_q;
	logic [BYTE_BITS-1:0] sym_hold_q;
	logic [LEN_W-1:0]     len_hold_q;
	logic [LEN_W-1:0]     final_bits_q;
	logic [BUF_W-1:0]     buf_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 end_q;
	logic                 pend_valid_q;
	logic [BYTE_BITS-1:0] pend_sym_q;
	logic [NSYM_W-1:0]    nsym_q;
	dec_kind_t            dec_kind_q;
	logic [BYTE_BITS-1:0] dec_sym_q;
	logic [LEN_W-1:0]     dec_len_q;

	logic                 out_valid_q;
	logic [BYTE_BITS-1:0] out_sym_q;
	logic                 out_symv_q;
	logic                 out_last_q;
	logic                 out_done_q;
	logic                 out_err_q;

	// The table is a shift chain: a new entry enters cell 0, so the most recently loaded
	// entry sits nearest the head and wins the priority as the token walks down the chain.
	entry_t ent_w  [MAX_ENTRIES+1];
	logic   vld_w  [MAX_ENTRIES+1];
	token_t tok_w  [MAX_ENTRIES+1];
	logic [MAX_ENTRIES-1:0] tok_vld;

	logic   in_xfer;
	logic   out_free;
	logic   cell_clear;
	logic   cell_push;
	logic   launch;
	query_t query;

	logic                 emit;
	logic [BYTE_BITS-1:0] emit_sym;
	logic                 emit_symv;
	logic                 emit_last;
	logic                 emit_done;
	logic                 emit_err;
	logic                 err_c;
	logic                 trunc;
	logic                 stall;
	logic [CNT_W-1:0]     new_cnt;
	logic [BUF_W:0]       new_mask;

	logic [TOTAL_W-1:0]   li_next;
	logic [LEN_W-1:0]     len_clamp;
	logic [LEN_W-1:0]     fin_clamp;
	logic [LEN_W-1:0]     app_n;
	logic [BYTE_BITS-1:0] app_bits;
	logic [BUF_W-1:0]     app_buf;

	assign in_xfer   = in_ch.valid && in_ch.ready;
	assign out_free  = !out_valid_q || out_ch.ready;
	assign in_ch.ready = (ctl_q == C_IDLE);

	assign query.bits   = buf_q;
	assign query.avail  = cnt_q;
	assign query.at_end = end_q;

	// Header decoding helpers.
	assign li_next   = load_index_q + TOTAL_W'(1);
	assign len_clamp = (in_ch.file_byte > BYTE_BITS'(CODE_BITS)) ? LEN_W'(CODE_BITS)
		: in_ch.file_byte[LEN_W-1:0];
	assign fin_clamp = (in_ch.file_byte > BYTE_BITS'(BYTE_BITS)) ? LEN_W'(BYTE_BITS)
		: in_ch.file_byte[LEN_W-1:0];

	// The final byte contributes only its leading valid bits, right-aligned.
	assign app_n    = in_ch.file_end ? final_bits_q : LEN_W'(BYTE_BITS);
	assign app_bits = in_ch.file_end ? (in_ch.file_byte >> (LEN_W'(BYTE_BITS) - final_bits_q))
		: in_ch.file_byte;
	assign app_buf  = (buf_q << app_n) | {8'd0, app_bits};

	assign cell_clear = in_xfer && (phase_q == PH_COUNT) && !in_ch.file_end;
	assign cell_push  = in_xfer && (phase_q == PH_TRIPLE) && !in_ch.file_end
		&& (tpos_q == 2'd2) && (load_index_q < TOTAL_W'(MAX_ENTRIES));
	assign launch     = (ctl_q == C_LAUNCH) && (cnt_q != '0);

	assign ent_w[0]     = '{sym: sym_hold_q, len: len_hold_q, code: in_ch.file_byte};
	assign vld_w[0]     = 1'b1;
	assign tok_w[0]     = '{valid: launch, kind: DEC_NONE, sym: '0, len: '0};

	for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
		pcd_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.clear     (cell_clear),
			.push      (cell_push),
			.entry_in  (ent_w[g]),
			.valid_in  (vld_w[g]),
			.query     (query),
			.tok_in    (tok_w[g]),
			.entry_out (ent_w[g+1]),
			.valid_out (vld_w[g+1]),
			.tok_out   (tok_w[g+1])
		);
		assign tok_vld[g] = tok_w[g+1].valid;
	end

	// Results of a byte are held back by one symbol, so the last one can carry the end
	// flags. A ninth symbol in one byte closes the run with an error on the eighth.
	always_comb begin
		new_cnt   = cnt_q - {1'b0, dec_len_q};
		new_mask  = (17'd1 << new_cnt) - 17'd1;
		err_c     = (dec_kind_q == DEC_NONE) || (end_q && cnt_q != '0);
		trunc     = pend_valid_q && (nsym_q == NSYM_W'(MAX_RES));
		emit      = 1'b0;
		emit_sym  = pend_sym_q;
		emit_symv = pend_valid_q;
		emit_last = 1'b1;
		emit_done = end_q;
		emit_err  = 1'b0;
		unique case (ctl_q)
			C_DECIDE: begin
				if (dec_kind_q == DEC_MATCH) begin
					emit      = pend_valid_q;
					emit_last = trunc;
					emit_done = trunc && end_q;
					emit_err  = trunc;
				end else begin
					emit     = pend_valid_q || err_c || end_q;
					emit_err = err_c;
				end
			end
			C_HDR_END: begin
				emit      = 1'b1;
				emit_symv = 1'b0;
				emit_done = 1'b1;
				emit_err  = 1'b1;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
		stall = emit && !out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_COUNT;
			ctl_q           <= C_IDLE;
			entries_total_q <= '0;
			load_index_q    <= '0;
			tpos_q          <= '0;
			final_bits_q    <= '0;
			buf_q           <= '0;
			cnt_q           <= '0;
			end_q           <= 1'b0;
			pend_valid_q    <= 1'b0;
			nsym_q          <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			if (emit && !stall) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (ctl_q)
				C_IDLE: begin
					if (in_xfer) begin
						if (phase_q == PH_DATA) begin
							buf_q        <= app_buf;
							cnt_q        <= cnt_q + CNT_W'(app_n);
							end_q        <= in_ch.file_end;
							pend_valid_q <= 1'b0;
							nsym_q       <= '0;
							ctl_q        <= C_LAUNCH;
						end else if (in_ch.file_end) begin
							ctl_q <= C_HDR_END;
						end else begin
							unique case (phase_q)
								PH_COUNT: begin
									entries_total_q <= {1'b0, in_ch.file_byte} + TOTAL_W'(1);
									load_index_q    <= '0;
									tpos_q          <= '0;
									phase_q         <= PH_TRIPLE;
								end
								PH_TRIPLE: begin
									if (tpos_q == 2'd2) begin
										tpos_q       <= '0;
										load_index_q <= li_next;
										if (li_next >= entries_total_q) begin
											phase_q <= PH_FINAL;
										end
									end else begin
										tpos_q <= tpos_q + 2'd1;
									end
								end
								PH_FINAL: begin
									final_bits_q <= fin_clamp;
									phase_q      <= PH_DATA;
								end
								default: begin
									phase_q <= phase_q;
								end
							endcase
						end
					end
				end
				C_LAUNCH: begin
					ctl_q <= (cnt_q == '0) ? C_DECIDE : C_SEARCH;
				end
				C_SEARCH: begin
					if (tok_w[MAX_ENTRIES].valid) begin
						ctl_q <= C_DECIDE;
					end
				end
				C_DECIDE: begin
					if (!stall) begin
						if (dec_kind_q == DEC_MATCH && !trunc) begin
							cnt_q        <= new_cnt;
							buf_q        <= buf_q & new_mask[BUF_W-1:0];
							pend_valid_q <= 1'b1;
							nsym_q       <= nsym_q + NSYM_W'(1);
							ctl_q        <= C_LAUNCH;
						end else begin
							ctl_q <= C_IDLE;
							if (end_q) begin
								phase_q         <= PH_COUNT;
								entries_total_q <= '0;
								load_index_q    <= '0;
								tpos_q          <= '0;
								final_bits_q    <= '0;
								buf_q           <= '0;
								cnt_q           <= '0;
							end else if (trunc || err_c) begin
								phase_q <= PH_DRAIN;
								buf_q   <= '0;
								cnt_q   <= '0;
							end
						end
					end
				end
				C_HDR_END: begin
					if (!stall) begin
						ctl_q           <= C_IDLE;
						phase_q         <= PH_COUNT;
						entries_total_q <= '0;
						load_index_q    <= '0;
						tpos_q          <= '0;
						final_bits_q    <= '0;
						buf_q           <= '0;
						cnt_q           <= '0;
					end
				end
				default: begin
					ctl_q <= C_IDLE;
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (in_xfer && phase_q == PH_TRIPLE) begin
			if (tpos_q == 2'd0) begin
				sym_hold_q <= in_ch.file_byte;
			end
			if (tpos_q == 2'd1) begin
				len_hold_q <= len_clamp;
			end
		end
		if (ctl_q == C_LAUNCH) begin
			dec_kind_q <= DEC_WAIT;
		end else if (ctl_q == C_SEARCH && tok_w[MAX_ENTRIES].valid) begin
			dec_kind_q <= tok_w[MAX_ENTRIES].kind;
			dec_sym_q  <= tok_w[MAX_ENTRIES].sym;
			dec_len_q  <= tok_w[MAX_ENTRIES].len;
		end
		if (ctl_q == C_DECIDE && !stall && dec_kind_q == DEC_MATCH && !trunc) begin
			pend_sym_q <= dec_sym_q;
		end
		if (emit && !stall) begin
			out_sym_q  <= emit_symv ? emit_sym : '0;
			out_symv_q <= emit_symv;
			out_last_q <= emit_last;
			out_done_q <= emit_done;
			out_err_q  <= emit_err;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.symbol       = out_sym_q;
	assign out_ch.symbol_valid = out_symv_q;
	assign out_ch.run_end      = out_last_q;
	assign out_ch.message_done = out_done_q;
	assign out_ch.decode_error = out_err_q;

	// At most one search token travels the chain at a time.
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_vld))
		else $error("more than one search token in the cell chain");

	// A token leaves the chain only while the sequencer is waiting for it.
	a_tail_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		tok_w[MAX_ENTRIES].valid |-> (ctl_q == C_SEARCH))
		else $error("search token arrived outside a search");

	// The bit buffer never holds more than fifteen pending bits.
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q < CNT_W'(BUF_W))
		else $error("bit buffer count out of range");

	// The end of a file always closes a run.
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_done_q |-> out_last_q)
		else $error("message end flagged on a result that does not end its run");

endmodule
